/* hw/rtl/lbsb_pkg.sv */
package lbsb_pkg;

  typedef enum logic [3:0] {
    ST_INIT      = 4'd0,
    ST_PROBE     = 4'd1,
    ST_ECHO      = 4'd2,
    ST_STATION   = 4'd3,
    ST_DHCP      = 4'd4,
    ST_STATIC    = 4'd5,
    ST_JOIN      = 4'd6,
    ST_SINGLE    = 4'd7,
    ST_SERVER    = 4'd8,
    ST_CONNECTED = 4'd9,
    ST_RETRY     = 4'd10
  } link_state_e;

  typedef enum logic [3:0] {
    CMD_PROBE  = 4'd0,
    CMD_ECHO   = 4'd1,
    CMD_STA    = 4'd2,
    CMD_DHCP   = 4'd3,
    CMD_STATIC = 4'd4,
    CMD_JOIN   = 4'd5,
    CMD_SINGLE = 4'd6,
    CMD_SERVER = 4'd7,
    CMD_STATUS = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESP  = 2'd1,
    KIND_EVENT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_NET_LOST = 2'd1,
    EV_CLOSED   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    REG_DHCP_EN    = 3'd0,
    REG_SERVER_EN  = 3'd1,
    REG_BACKOFF_IN = 3'd2,
    REG_BACKOFF_MX = 3'd3,
    REG_HEALTH     = 3'd4
  } reg_idx_e;

  localparam int unsigned MsW = 16;

  localparam logic [MsW-1:0] BackoffInitRst = 16'd2000;
  localparam logic [MsW-1:0] BackoffMaxRst  = 16'd60000;
  localparam logic [MsW-1:0] HealthRst      = 16'd5000;

  localparam logic signed [3:0] StatusJoinLost  = 4'sd5;
  localparam logic signed [3:0] StatusServer    = 4'sd4;
  localparam logic signed [3:0] StatusServerOpt = 4'sd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic              resp_ok;
    logic              resp_already;
    logic signed [3:0] status_code;
    logic [1:0]        event_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0]     link_state;
    logic           cmd_valid;
    logic [3:0]     cmd_id;
    logic           connected;
    logic [MsW-1:0] retry_delay_ms;
  } out_item_t;

endpackage

/* hw/rtl/link_bringup_sequencer_backoff.sv */
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless stalled; the state update is one pass of logic.
// Decoupling: the input register can take a new item while a result waits, if it is empty.
// Reset: config registers go to 1, 1, 2000, 60000, 5000; link state to init,
// retry goal to probe, delay to 2000, counters and the status flag to zero.
module link_bringup_sequencer_backoff
  import lbsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [MsW-1:0] cfg_data_i
);

  function automatic logic [MsW-1:0] sat_inc(input logic [MsW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic           dhcp_en_q, server_en_q;
  logic [MsW-1:0] backoff_init_q, backoff_max_q, health_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dhcp_en_q      <= 1'b1;
      server_en_q    <= 1'b1;
      backoff_init_q <= BackoffInitRst;
      backoff_max_q  <= BackoffMaxRst;
      health_q       <= HealthRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DHCP_EN:    dhcp_en_q      <= cfg_data_i[0];
        REG_SERVER_EN:  server_en_q    <= cfg_data_i[0];
        REG_BACKOFF_IN: backoff_init_q <= cfg_data_i;
        REG_BACKOFF_MX: backoff_max_q  <= cfg_data_i;
        REG_HEALTH:     health_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic     item_valid_q;
  in_item_t item_q;
  logic     advance;
  logic     out_valid_q;
  out_item_t out_q;

  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // link state
  link_state_e    state_q, state_d, goal_q, goal_d, go_st, rt_goal;
  logic [MsW-1:0] delay_q, delay_d, since_entry_q, since_entry_d;
  logic [MsW-1:0] since_health_q, since_health_d, se_inc, sh_inc, rt_base;
  logic [MsW:0]   rt_dbl;
  logic           await_q, await_d, go_en, rt_en, rt_reset, cmd_v;
  logic [3:0]     cmd_id;

  always_comb begin
    state_d        = state_q;
    goal_d         = goal_q;
    delay_d        = delay_q;
    since_entry_d  = since_entry_q;
    since_health_d = since_health_q;
    await_d        = await_q;
    go_en          = 1'b0;
    go_st          = state_q;
    rt_en          = 1'b0;
    rt_reset       = 1'b0;
    rt_goal        = ST_PROBE;
    cmd_v          = 1'b0;
    cmd_id         = CMD_PROBE;
    se_inc         = sat_inc(since_entry_q);
    sh_inc         = sat_inc(since_health_q);
    rt_base        = '0;
    rt_dbl         = '0;

    case (item_q.kind)
      KIND_TICK: begin
        if (state_q == ST_INIT) begin
          go_en = 1'b1;
          go_st = ST_PROBE;
        end else if (state_q == ST_RETRY) begin
          since_entry_d = se_inc;
          if (se_inc >= delay_q) begin
            go_en = 1'b1;
            go_st = goal_q;
          end
        end else if (state_q == ST_CONNECTED) begin
          since_entry_d = se_inc;
          if (!await_q) begin
            since_health_d = sh_inc;
            if (sh_inc >= health_q) begin
              since_health_d = '0;
              await_d        = 1'b1;
              cmd_v          = 1'b1;
              cmd_id         = CMD_STATUS;
            end
          end
        end else begin
          since_entry_d = se_inc;
        end
      end
      KIND_RESP: begin
        case (state_q)
          ST_PROBE, ST_STATION, ST_STATIC, ST_SINGLE: begin
            if (item_q.resp_ok) begin
              go_en = 1'b1;
              unique case (state_q)
                ST_PROBE:   go_st = ST_ECHO;
                ST_STATION: go_st = ST_DHCP;
                ST_STATIC:  go_st = ST_JOIN;
                default:    go_st = server_en_q ? ST_SERVER : ST_CONNECTED;
              endcase
            end else begin
              rt_en   = 1'b1;
              rt_goal = state_q;
            end
          end
          ST_ECHO: begin
            go_en = 1'b1;
            go_st = ST_STATION;
          end
          ST_DHCP: begin
            if (item_q.resp_ok) begin
              go_en = 1'b1;
              go_st = dhcp_en_q ? ST_JOIN : ST_STATIC;
            end else begin
              rt_en   = 1'b1;
              rt_goal = ST_DHCP;
            end
          end
          ST_JOIN: begin
            if (item_q.resp_ok) begin
              delay_d = backoff_init_q;
              go_en   = 1'b1;
              go_st   = ST_SINGLE;
            end else begin
              rt_en   = 1'b1;
              rt_goal = ST_JOIN;
            end
          end
          ST_SERVER: begin
            if (item_q.resp_ok || item_q.resp_already) begin
              delay_d = backoff_init_q;
              go_en   = 1'b1;
              go_st   = ST_CONNECTED;
            end else begin
              rt_en   = 1'b1;
              rt_goal = ST_SERVER;
            end
          end
          ST_CONNECTED: begin
            if (await_q) begin
              await_d = 1'b0;
              if (!item_q.resp_ok || item_q.status_code == StatusJoinLost ||
                  item_q.status_code < 0) begin
                rt_en    = 1'b1;
                rt_reset = 1'b1;
                rt_goal  = ST_JOIN;
              end else if (item_q.status_code == StatusServer ||
                           (item_q.status_code == StatusServerOpt && server_en_q)) begin
                rt_en    = 1'b1;
                rt_reset = 1'b1;
                rt_goal  = ST_SERVER;
              end
            end
          end
          default: ;
        endcase
      end
      KIND_EVENT: begin
        if (state_q == ST_CONNECTED) begin
          if (item_q.event_code == EV_NET_LOST) begin
            rt_en    = 1'b1;
            rt_reset = 1'b1;
            rt_goal  = ST_JOIN;
          end else if (item_q.event_code == EV_CLOSED && server_en_q) begin
            rt_en    = 1'b1;
            rt_reset = 1'b1;
            rt_goal  = ST_SERVER;
          end
        end
      end
      default: ;
    endcase

    if (rt_en) begin
      rt_base = rt_reset ? backoff_init_q : delay_q;
      rt_dbl  = {rt_base, 1'b0};
      delay_d = (rt_dbl > {1'b0, backoff_max_q}) ? backoff_max_q : rt_dbl[MsW-1:0];
      goal_d  = rt_goal;
      await_d = 1'b0;
      go_en   = 1'b1;
      go_st   = ST_RETRY;
    end

    if (go_en) begin
      state_d       = go_st;
      since_entry_d = '0;
      if (go_st inside {ST_PROBE, ST_ECHO, ST_STATION, ST_DHCP, ST_STATIC,
                        ST_JOIN, ST_SINGLE, ST_SERVER}) begin
        cmd_v  = 1'b1;
        cmd_id = 4'(go_st) - 4'd1;
      end
      if (go_st == ST_CONNECTED) begin
        since_health_d = '0;
        await_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      goal_q         <= ST_PROBE;
      delay_q        <= BackoffInitRst;
      since_entry_q  <= '0;
      since_health_q <= '0;
      await_q        <= 1'b0;
    end else if (advance) begin
      state_q        <= state_d;
      goal_q         <= goal_d;
      delay_q        <= delay_d;
      since_entry_q  <= since_entry_d;
      since_health_q <= since_health_d;
      await_q        <= await_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.link_state     <= 4'(state_d);
      out_q.cmd_valid      <= cmd_v;
      out_q.cmd_id         <= cmd_id;
      out_q.connected      <= (state_d == ST_CONNECTED);
      out_q.retry_delay_ms <= delay_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lbsb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles = 120;
  localparam int NumDirA = 7;
  localparam int NumDir = 25;
  localparam logic [3:0] NoCmd = 4'd0;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam logic [1:0] EvUnused = 2'd3;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic           clk_i;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  in_item_t       in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_item_t      out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [2:0]     cfg_index_i = '0;
  logic [MsW-1:0] cfg_data_i = '0;

  link_bringup_sequencer_backoff DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // link model state
  logic           cf_dhcp;
  logic           cf_server;
  logic [MsW-1:0] cf_init;
  logic [MsW-1:0] cf_max;
  logic [MsW-1:0] cf_health;
  link_state_e    lk_state;
  link_state_e    lk_goal;
  logic [MsW-1:0] lk_delay;
  logic [MsW-1:0] lk_since_entry;
  logic [MsW-1:0] lk_since_health;
  logic           lk_awaiting;
  logic           nx_cmd_v;
  logic [3:0]     nx_cmd_id;

  out_item_t   pending_reports [$];
  dir_row_t    dir_rows [NumDir];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  int          stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_link();
    cf_dhcp = 1'b1;
    cf_server = 1'b1;
    cf_init = BackoffInitRst;
    cf_max = BackoffMaxRst;
    cf_health = HealthRst;
    lk_state = ST_INIT;
    lk_goal = ST_PROBE;
    lk_delay = BackoffInitRst;
    lk_since_entry = '0;
    lk_since_health = '0;
    lk_awaiting = 1'b0;
  endfunction

  function automatic logic [MsW-1:0] sat_inc(logic [MsW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void move_to(link_state_e s);
    lk_state = s;
    lk_since_entry = '0;
    if (s >= ST_PROBE && s <= ST_SERVER) begin
      nx_cmd_v = 1'b1;
      nx_cmd_id = s - 4'd1;
    end
    if (s == ST_CONNECTED) begin
      lk_since_health = '0;
      lk_awaiting = 1'b0;
    end
  endfunction

  function automatic void back_off(link_state_e goal);
    logic [MsW:0] d;
    d = {lk_delay, 1'b0};
    if (d > {1'b0, cf_max}) d = {1'b0, cf_max};
    lk_delay = d[MsW-1:0];
    lk_goal = goal;
    lk_awaiting = 1'b0;
    move_to(ST_RETRY);
  endfunction

  function automatic void restart_backoff(link_state_e goal);
    lk_delay = cf_init;
    back_off(goal);
  endfunction

  function automatic out_item_t step_link(in_item_t it);
    out_item_t r;
    logic signed [3:0] st;
    nx_cmd_v = 1'b0;
    nx_cmd_id = NoCmd;
    case (it.kind)
      KIND_TICK: begin
        if (lk_state == ST_INIT) begin
          move_to(ST_PROBE);
        end else if (lk_state == ST_RETRY) begin
          lk_since_entry = sat_inc(lk_since_entry);
          if (lk_since_entry >= lk_delay) move_to(lk_goal);
        end else if (lk_state == ST_CONNECTED) begin
          lk_since_entry = sat_inc(lk_since_entry);
          if (!lk_awaiting) begin
            lk_since_health = sat_inc(lk_since_health);
            if (lk_since_health >= cf_health) begin
              lk_since_health = '0;
              lk_awaiting = 1'b1;
              nx_cmd_v = 1'b1;
              nx_cmd_id = CMD_STATUS;
            end
          end
        end else begin
          lk_since_entry = sat_inc(lk_since_entry);
        end
      end
      KIND_RESP: begin
        case (lk_state)
          ST_PROBE: if (it.resp_ok) move_to(ST_ECHO); else back_off(ST_PROBE);
          ST_ECHO: move_to(ST_STATION);
          ST_STATION: if (it.resp_ok) move_to(ST_DHCP); else back_off(ST_STATION);
          ST_DHCP: begin
            if (it.resp_ok) move_to(cf_dhcp ? ST_JOIN : ST_STATIC);
            else back_off(ST_DHCP);
          end
          ST_STATIC: if (it.resp_ok) move_to(ST_JOIN); else back_off(ST_STATIC);
          ST_JOIN: begin
            if (it.resp_ok) begin
              lk_delay = cf_init;
              move_to(ST_SINGLE);
            end else begin
              back_off(ST_JOIN);
            end
          end
          ST_SINGLE: begin
            if (it.resp_ok) move_to(cf_server ? ST_SERVER : ST_CONNECTED);
            else back_off(ST_SINGLE);
          end
          ST_SERVER: begin
            if (it.resp_ok || it.resp_already) begin
              lk_delay = cf_init;
              move_to(ST_CONNECTED);
            end else begin
              back_off(ST_SERVER);
            end
          end
          ST_CONNECTED: begin
            if (lk_awaiting) begin
              st = it.resp_ok ? it.status_code : -4'sd1;
              lk_awaiting = 1'b0;
              if (st == StatusJoinLost || st < 0) begin
                restart_backoff(ST_JOIN);
              end else if (st == StatusServer || (st == StatusServerOpt && cf_server)) begin
                restart_backoff(ST_SERVER);
              end
            end
          end
          default: ;
        endcase
      end
      KIND_EVENT: begin
        if (lk_state == ST_CONNECTED) begin
          if (it.event_code == EV_NET_LOST) restart_backoff(ST_JOIN);
          else if (it.event_code == EV_CLOSED && cf_server) restart_backoff(ST_SERVER);
        end
      end
      default: ;
    endcase
    r.link_state = lk_state;
    r.cmd_valid = nx_cmd_v;
    r.cmd_id = nx_cmd_v ? nx_cmd_id : NoCmd;
    r.connected = (lk_state == ST_CONNECTED);
    r.retry_delay_ms = lk_delay;
    return r;
  endfunction

  // mostly well-formed traffic for the current state, some pure noise
  function automatic in_item_t pick_item();
    in_item_t    it;
    logic [31:0] raw;
    int unsigned roll;
    raw = $urandom;
    it = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 99) < 6) return it;
    roll = $urandom_range(0, 99);
    case (lk_state)
      ST_INIT: it.kind = KIND_TICK;
      ST_RETRY: it.kind = (roll < 85) ? KIND_TICK : KIND_RESP;
      ST_CONNECTED: begin
        if (lk_awaiting) it.kind = (roll < 65) ? KIND_RESP : (roll < 85) ? KIND_TICK : KIND_EVENT;
        else it.kind = (roll < 70) ? KIND_TICK : (roll < 85) ? KIND_EVENT : KIND_RESP;
      end
      default: it.kind = (roll < 75) ? KIND_RESP : KIND_TICK;
    endcase
    if (it.kind == KIND_RESP) it.resp_ok = ($urandom_range(0, 99) < 82);
    return it;
  endfunction

  task automatic drive_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = step_link(it);
    pending_reports.push_back(typed ? want : pred);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) drive_item(pick_item(), 1'b0, '0);
  endtask

  task automatic close_phase();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [MsW-1:0] dh, input logic [MsW-1:0] sv,
                          input logic [MsW-1:0] bi, input logic [MsW-1:0] bm,
                          input logic [MsW-1:0] hi);
    logic [MsW-1:0] v [5];
    v = '{dh, sv, bi, bm, hi};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= reg_idx_e'(i);
      cfg_data_i <= v[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (reg_idx_e'(i))
        REG_DHCP_EN:    cf_dhcp = v[i][0];
        REG_SERVER_EN:  cf_server = v[i][0];
        REG_BACKOFF_IN: cf_init = v[i];
        REG_BACKOFF_MX: cf_max = v[i];
        REG_HEALTH:     cf_health = v[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic [MsW-1:0] want,
                             input logic [MsW-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : report_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t report: expected none, got %0h", $time, out_data_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("link_state", want.link_state, out_data_o.link_state);
        check_field("cmd_valid", want.cmd_valid, out_data_o.cmd_valid);
        check_field("cmd_id", want.cmd_id, out_data_o.cmd_id);
        check_field("connected", want.connected, out_data_o.connected);
        check_field("retry_delay_ms", want.retry_delay_ms, out_data_o.retry_delay_ms);
      end
    end
  end

  // receiver: one long hold-off on request, otherwise random stall modes
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(8, 60);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        mode_left--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_link();
    // stim {kind, ok, already, status, event}, typed, want {state, cmd_v, cmd, conn, delay}
    dir_rows = '{
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_INIT,  1'b0, NoCmd,      1'b0, 16'd2000},
      {KIND_EVENT, 1'b0, 1'b0, 4'sh0, EV_NET_LOST, 1'b1, ST_INIT,  1'b0, NoCmd,      1'b0, 16'd2000},
      {KindUnused, 1'b1, 1'b1, 4'sh7, EvUnused,    1'b1, ST_INIT,  1'b0, NoCmd,      1'b0, 16'd2000},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_PROBE, 1'b1, CMD_PROBE,  1'b0, 16'd2000},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_ECHO,  1'b1, CMD_ECHO,   1'b0, 16'd2000},
      {KIND_RESP,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_STATION, 1'b1, CMD_STA,  1'b0, 16'd2000},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_STATION, 1'b0, NoCmd,    1'b0, 16'd2000},
      {KIND_RESP,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_STATION, 1'b1, CMD_STA,  1'b0, 16'd2},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_DHCP,  1'b1, CMD_DHCP,   1'b0, 16'd2},
      {KIND_RESP,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_DHCP,  1'b1, CMD_DHCP,   1'b0, 16'd2},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_STATIC, 1'b1, CMD_STATIC, 1'b0, 16'd2},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_JOIN,  1'b1, CMD_JOIN,   1'b0, 16'd2},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_SINGLE, 1'b1, CMD_SINGLE, 1'b0, 16'd1},
      {KIND_RESP,  1'b1, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_SERVER, 1'b1, CMD_SERVER, 1'b0, 16'd1},
      {KIND_RESP,  1'b0, 1'b1, 4'sh0, EV_NONE,     1'b1, ST_CONNECTED, 1'b0, NoCmd,   1'b1, 16'd1},
      {KIND_RESP,  1'b1, 1'b0, 4'sh5, EV_NONE,     1'b1, ST_CONNECTED, 1'b0, NoCmd,   1'b1, 16'd1},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_CONNECTED, 1'b1, CMD_STATUS, 1'b1, 16'd1},
      {KIND_EVENT, 1'b0, 1'b0, 4'sh0, EV_NONE,     1'b0, ST_INIT,  1'b0, NoCmd,      1'b0, 16'd0},
      {KIND_RESP,  1'b1, 1'b0, 4'sh8, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_RETRY, 1'b0, NoCmd,      1'b0, 16'd2},
      {KIND_TICK,  1'b0, 1'b0, 4'sh0, EV_NONE,     1'b1, ST_JOIN,  1'b1, CMD_JOIN,   1'b0, 16'd2}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirA; i++) begin
      drive_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end
    close_phase();
    set_regs(16'd0, 16'd1, 16'd1, 16'd2, 16'd1);
    for (int i = NumDirA; i < NumDir; i++) begin
      drive_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end
    close_phase();

    set_regs(16'd1, 16'd1, 16'd1, 16'd4, 16'd3);
    hold_req = 1'b1;
    run_random(130);
    close_phase();
    set_regs(16'd0, 16'd0, 16'd2, 16'd16, 16'd1);
    run_random(130);
    close_phase();
    // cap below the initial delay
    set_regs(16'd0, 16'd1, 16'd3, 16'd1, 16'd2);
    run_random(110);
    close_phase();
    set_regs(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(30);
    close_phase();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lbsb_pkg.sv
hw/rtl/link_bringup_sequencer_backoff.sv
tb/tb_top.sv
